// ===== hw/rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and codes of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int LOOP_W      = 16;
  localparam int OUT_COORD_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_COLS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHEET_ROWS     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_END_POSITION   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PERIOD   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOPS          = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PINGPONG       = 3'd6;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PLAY    = 2'd1;
  localparam logic [1:0] CMD_PAUSE   = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  typedef enum logic [1:0] {
    MODE_PLAY    = 2'd0,
    MODE_PAUSE   = 2'd1,
    MODE_END     = 2'd2,
    MODE_RESTART = 2'd3
  } mode_t;

  typedef struct packed {
    logic [8:0]  sheet_cols;
    logic [8:0]  sheet_rows;
    logic [15:0] start_position;
    logic [15:0] end_position;
    logic [23:0] frame_period;
    logic [15:0] loops_to_complete;
    logic        pingpong_enable;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic               backward;
    logic [LOOP_W-1:0]  loops_done;
  } ctrl_t;

endpackage

// ===== hw/rtl/sfs_in_if.sv =====
// ----------------------------------------------------------------------------
// sfs_in_if
// Command channel: one word carries a command and a time delta.
// ----------------------------------------------------------------------------
interface sfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] delta_time;

  modport source (output valid, output command, output delta_time, input ready);
  modport sink (input valid, input command, input delta_time, output ready);
endinterface

// ===== hw/rtl/sfs_out_if.sv =====
// ----------------------------------------------------------------------------
// sfs_out_if
// Frame channel: one word per command with cursor, mode and direction.
// ----------------------------------------------------------------------------
interface sfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_col;
  logic [7:0] frame_row;
  logic [1:0] play_state;
  logic       reversing;

  modport source (output valid, output frame_col, output frame_row,
                  output play_state, output reversing, input ready);
  modport sink (input valid, input frame_col, input frame_row,
                input play_state, input reversing, output ready);
endinterface

// ===== hw/rtl/sfs_config.sv =====
// ----------------------------------------------------------------------------
// sfs_config
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module sfs_config (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sfs_pkg::cfg_t                  cfg
);
  import sfs_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sheet_cols        <= 9'd1;
      regs.sheet_rows        <= 9'd1;
      regs.start_position    <= '0;
      regs.end_position      <= '0;
      regs.frame_period      <= '0;
      regs.loops_to_complete <= '0;
      regs.pingpong_enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHEET_COLS:     regs.sheet_cols        <= cfg_data[8:0];
        REG_SHEET_ROWS:     regs.sheet_rows        <= cfg_data[8:0];
        REG_START_POSITION: regs.start_position    <= cfg_data[15:0];
        REG_END_POSITION:   regs.end_position      <= cfg_data[15:0];
        REG_FRAME_PERIOD:   regs.frame_period      <= cfg_data[23:0];
        REG_LOOPS:          regs.loops_to_complete <= cfg_data[15:0];
        REG_PINGPONG:       regs.pingpong_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;
endmodule

// ===== hw/rtl/sfs_step.sv =====
// ----------------------------------------------------------------------------
// sfs_step
// Next-state logic for one command word: mode, timer, cursor and loops.
// ----------------------------------------------------------------------------
module sfs_step #(
  parameter int COORD_BITS = 8,
  parameter int TIMER_BITS = 24
) (
  input  sfs_pkg::cfg_t          cfg,
  input  logic [1:0]             command,
  input  logic [15:0]            delta_time,
  input  logic [COORD_BITS-1:0]  col,
  input  logic [COORD_BITS-1:0]  row,
  input  logic [TIMER_BITS-1:0]  elapsed,
  input  sfs_pkg::ctrl_t         ctrl,
  output logic [COORD_BITS-1:0]  col_next,
  output logic [COORD_BITS-1:0]  row_next,
  output logic [TIMER_BITS-1:0]  elapsed_next,
  output sfs_pkg::ctrl_t         ctrl_next
);
  import sfs_pkg::*;

  localparam int LIM = 1 << COORD_BITS;
  localparam int SW  = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;
  localparam int CW  = (TIMER_BITS > 24) ? TIMER_BITS : 24;
  localparam logic [SW-1:0] TMAX = {{(SW-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

  function automatic ctrl_t count_loop(ctrl_t c, logic [LOOP_W-1:0] target);
    ctrl_t r;
    r = c;
    if (c.loops_done != '1) r.loops_done = c.loops_done + LOOP_W'(1);
    if (target != '0 && r.loops_done >= target) r.mode = MODE_END;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] size_m1(logic [8:0] v);
    logic [COORD_BITS-1:0] r;
    if (v == 9'd0) r = '0;
    else if (32'(v) > LIM) r = '1;
    else r = COORD_BITS'(v - 9'd1);
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(logic [7:0] v,
                                                 logic [COORD_BITS-1:0] m1);
    logic [COORD_BITS-1:0] r;
    if (32'(v) > 32'(m1)) r = m1;
    else r = COORD_BITS'(v);
    return r;
  endfunction

  logic [COORD_BITS-1:0] cols_m1, rows_m1, sc, sr, ec, er;
  logic [COORD_BITS-1:0] c0, r0, c2, r2;
  logic [TIMER_BITS-1:0] e0, e1;
  logic [SW-1:0]         sum;
  ctrl_t                 k0, k1;
  logic                  fire;

  assign cols_m1 = size_m1(cfg.sheet_cols);
  assign rows_m1 = size_m1(cfg.sheet_rows);
  assign sc = clamp(cfg.start_position[7:0], cols_m1);
  assign sr = clamp(cfg.start_position[15:8], rows_m1);
  assign ec = clamp(cfg.end_position[7:0], cols_m1);
  assign er = clamp(cfg.end_position[15:8], rows_m1);

  always_comb begin
    c0 = col;
    r0 = row;
    e0 = elapsed;
    k0 = ctrl;
    if (ctrl.mode == MODE_END || ctrl.mode == MODE_RESTART) begin
      c0 = sc;
      r0 = sr;
    end
    if (ctrl.mode == MODE_RESTART) begin
      e0 = '0;
      k0.loops_done = '0;
      k0.backward = 1'b0;
      k0.mode = MODE_PLAY;
    end
    sum = SW'(e0) + SW'(delta_time);
    e1 = (sum > TMAX) ? '1 : TIMER_BITS'(sum);
    fire = (CW'(e1) >= CW'(cfg.frame_period)) && (k0.mode == MODE_PLAY);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    elapsed_next = elapsed;
    ctrl_next = ctrl;
    k1 = k0;
    c2 = c0;
    r2 = r0;
    case (command)
      CMD_PLAY:    ctrl_next.mode = MODE_PLAY;
      CMD_PAUSE:   ctrl_next.mode = MODE_PAUSE;
      CMD_RESTART: ctrl_next.mode = MODE_RESTART;
      CMD_TICK: begin
        col_next = c0;
        row_next = r0;
        ctrl_next = k0;
        elapsed_next = e1;
        if (fire) begin
          elapsed_next = '0;
          if (!(sc == ec && sr == er && c0 == sc && r0 == sr)) begin
            if (c0 >= ec && r0 >= er) begin
              k1 = count_loop(k0, cfg.loops_to_complete);
              if (cfg.pingpong_enable) k1.backward = 1'b1;
            end
            if (c0 >= ec && r0 >= er && !cfg.pingpong_enable) begin
              col_next = sc;
              row_next = sr;
              ctrl_next = k1;
            end else begin
              if (!k1.backward) begin
                if (c0 < cols_m1) begin
                  c2 = c0 + COORD_BITS'(1);
                end else begin
                  c2 = '0;
                  r2 = (r0 < rows_m1) ? r0 + COORD_BITS'(1) : '0;
                end
              end else begin
                if (c0 > '0) begin
                  c2 = c0 - COORD_BITS'(1);
                end else begin
                  c2 = cols_m1;
                  r2 = (r0 > '0) ? r0 - COORD_BITS'(1) : rows_m1;
                end
              end
              col_next = c2;
              row_next = r2;
              ctrl_next = k1;
              if (k1.backward && c2 <= sc && r2 <= sr) begin
                ctrl_next = count_loop(k1, cfg.loops_to_complete);
                ctrl_next.backward = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== hw/rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Output: the frame word is registered and appears in the cycle after its command word is accepted.
// Throughput: 1 word per cycle; the state update is combinational, and
// a frame word held by the sink stalls the command channel until it is taken.
// Reset: cursor, timer and loop count clear, mode goes to restart pending.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
  parameter int COORD_BITS = 8,
  parameter int TIMER_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  sfs_in_if.sink                          cmd,
  sfs_out_if.source                       frame,
  input  logic                            cfg_we,
  input  logic [sfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sfs_pkg::*;

  cfg_t                  cfg;
  logic [COORD_BITS-1:0] cursor_col, cursor_row, col_next, row_next;
  logic [TIMER_BITS-1:0] elapsed, elapsed_next;
  ctrl_t                 ctrl, ctrl_next;
  logic                  out_valid;
  logic                  ready;
  logic                  accept;

  sfs_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfs_step #(
    .COORD_BITS (COORD_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg          (cfg),
    .command      (cmd.command),
    .delta_time   (cmd.delta_time),
    .col          (cursor_col),
    .row          (cursor_row),
    .elapsed      (elapsed),
    .ctrl         (ctrl),
    .col_next     (col_next),
    .row_next     (row_next),
    .elapsed_next (elapsed_next),
    .ctrl_next    (ctrl_next)
  );

  assign ready  = !out_valid || frame.ready;
  assign accept = cmd.valid && ready;
  assign cmd.ready = ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col      <= '0;
      cursor_row      <= '0;
      elapsed         <= '0;
      ctrl.mode       <= MODE_RESTART;
      ctrl.backward   <= 1'b0;
      ctrl.loops_done <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        cursor_col <= col_next;
        cursor_row <= row_next;
        elapsed    <= elapsed_next;
        ctrl       <= ctrl_next;
        out_valid  <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frame.frame_col  <= OUT_COORD_W'(col_next);
      frame.frame_row  <= OUT_COORD_W'(row_next);
      frame.play_state <= ctrl_next.mode;
      frame.reversing  <= ctrl_next.backward;
    end
  end

  assign frame.valid = out_valid;

`ifndef NO_ASSERTIONS
  a_word_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> frame.valid)
    else $error("accepted command produced no frame word");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == CMD_RESTART |=> frame.play_state == MODE_RESTART)
    else $error("restart command did not report restart pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(cursor_col) && $stable(cursor_row) && $stable(elapsed))
    else $error("state moved without an accepted command");
`endif
endmodule
